@@ hdl/assert_macros.svh @@
// Assertion macros used by the evaluator top level.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define HPE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("horner evaluator check failed");

// Checked on every clock edge, reset included.
`define HPE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("horner evaluator reset check failed");

`endif

@@ hdl/hpe_pkg.sv @@
// Shared constants and types of the Horner polynomial evaluator.
// No dependencies; imported by hpe_horner_step and the top level.
package hpe_pkg;

    localparam int MAX_DEGREE = 6;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DEG_W      = 3;
    localparam int COEF_IDX_W = $clog2(MAX_DEGREE + 1);
    localparam int CFG_IDX_W  = $clog2(MAX_DEGREE + 2);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = CFG_IDX_W'(MAX_DEGREE + 1);

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One pipeline slot: the point, the running accumulator and the sticky flag.
    typedef struct packed {
        logic valid;
        logic ovf;
        q_t   x;
        q_t   acc;
    } stage_t;

    typedef struct packed {
        q_t   value;
        logic ovf;
    } result_t;

endpackage

@@ hdl/hpe_horner_step.sv @@
// One Horner step in two register stages: multiply, then shift, saturate and add.
// Depends on hpe_pkg.
module hpe_horner_step
    import hpe_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   active,
    input  q_t     coef,
    input  stage_t in_stage,
    output stage_t out_stage
);

    logic                     mul_valid_reg;
    logic                     mul_ovf_reg;
    logic                     mul_active_reg;
    q_t                       mul_x_reg;
    q_t                       mul_acc_reg;
    logic signed [PROD_W-1:0] mul_prod_reg;
    logic signed [PROD_W-1:0] mul_prod_next;

    stage_t                   out_reg;
    stage_t                   out_next;

    logic                     prod_pos_sat;
    logic                     prod_neg_sat;
    q_t                       prod_q;
    logic signed [DATA_W:0]   sum_wide;
    logic                     sum_pos_sat;
    logic                     sum_neg_sat;
    q_t                       sum_q;

    // Full signed product; both operands are sign-extended to the product width.
    assign mul_prod_next = PROD_W'(in_stage.x) * PROD_W'(in_stage.acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_ovf_reg    <= in_stage.ovf;
            mul_active_reg <= active;
            mul_x_reg      <= in_stage.x;
            mul_acc_reg    <= in_stage.acc;
            mul_prod_reg   <= mul_prod_next;
        end
    end

    // Dropping the low fraction bits of a two's complement product is a floor.
    always_comb begin
        prod_pos_sat = !mul_prod_reg[PROD_W-1]
                       && (|mul_prod_reg[PROD_W-2:DATA_W+FRAC_W-1]);
        prod_neg_sat = mul_prod_reg[PROD_W-1]
                       && !(&mul_prod_reg[PROD_W-2:DATA_W+FRAC_W-1]);
        if (prod_pos_sat) begin
            prod_q = Q_MAX;
        end else if (prod_neg_sat) begin
            prod_q = Q_MIN;
        end else begin
            prod_q = mul_prod_reg[DATA_W+FRAC_W-1:FRAC_W];
        end

        sum_wide    = {prod_q[DATA_W-1], prod_q} + {coef[DATA_W-1], coef};
        sum_pos_sat = !sum_wide[DATA_W] && sum_wide[DATA_W-1];
        sum_neg_sat = sum_wide[DATA_W] && !sum_wide[DATA_W-1];
        if (sum_pos_sat) begin
            sum_q = Q_MAX;
        end else if (sum_neg_sat) begin
            sum_q = Q_MIN;
        end else begin
            sum_q = sum_wide[DATA_W-1:0];
        end

        out_next.valid = mul_valid_reg;
        out_next.x     = mul_x_reg;
        if (mul_active_reg) begin
            out_next.acc = sum_q;
            out_next.ovf = mul_ovf_reg | prod_pos_sat | prod_neg_sat
                           | sum_pos_sat | sum_neg_sat;
        end else begin
            out_next.acc = mul_acc_reg;
            out_next.ovf = mul_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= out_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.ovf <= out_next.ovf;
            out_reg.x   <= out_next.x;
            out_reg.acc <= out_next.acc;
        end
    end

    assign out_stage = out_reg;

endmodule

@@ hdl/horner_polynomial_evaluator.sv @@
// Top level of the Horner polynomial evaluator: config registers, pipeline, output skid.
// Depends on hpe_pkg, hpe_horner_step and assert_macros.svh.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      s_x_value
//   m_        out        m_valid / m_ready      m_poly_value, m_overflow
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle while s_ready is high. The pipeline has one
// input stage, two stages per Horner step, and the output register.
// The multiply of each Horner step sets the pipeline depth.
// aresetn is synchronous; it clears all valid bits and the configuration registers.
// A stall fills the skid register, and the pipeline then holds as a whole.
`include "assert_macros.svh"

module horner_polynomial_evaluator
    import hpe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  q_t                   s_x_value,

    output logic                 m_valid,
    input  logic                 m_ready,
    output q_t                   m_poly_value,
    output logic                 m_overflow,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    // Configuration registers; every stage reads them directly. The user must change
    // them only while the block is idle; the block itself does not enforce this.
    logic [DEG_W-1:0]      degree_reg;
    q_t                    coef_reg [MAX_DEGREE+1];
    logic [COEF_IDX_W-1:0] degree_eff;
    logic [MAX_DEGREE-1:0] step_active;

    stage_t                stage0_reg;
    stage_t                chain [MAX_DEGREE+1];
    stage_t                last_stage;
    logic                  pipe_en;

    logic                  out_valid_reg;
    result_t               out_data_reg;
    logic                  skid_valid_reg;
    result_t               skid_data_reg;
    result_t               last_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= '0;
            for (int k = 0; k <= MAX_DEGREE; k++) begin
                coef_reg[k] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == CFG_DEGREE) begin
                degree_reg <= cfg_data[DEG_W-1:0];
            end else if (cfg_index >= CFG_COEF_BASE && cfg_index <= CFG_COEF_LAST) begin
                coef_reg[COEF_IDX_W'(cfg_index - CFG_COEF_BASE)] <= cfg_data;
            end
            // Indexes past the last coefficient are ignored.
        end
    end

    // A degree beyond the supported maximum behaves as the maximum.
    always_comb begin
        if (32'(degree_reg) > MAX_DEGREE) begin
            degree_eff = COEF_IDX_W'(MAX_DEGREE);
        end else begin
            degree_eff = COEF_IDX_W'(degree_reg);
        end
    end

    // The whole pipeline moves together unless the skid register is holding an item.
    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // The input stage loads the top coefficient in use as the accumulator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage0_reg.valid <= 1'b0;
        end else if (pipe_en) begin
            stage0_reg.valid <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            stage0_reg.ovf <= 1'b0;
            stage0_reg.x   <= s_x_value;
            stage0_reg.acc <= coef_reg[degree_eff];
        end
    end

    assign chain[0] = stage0_reg;

    // Step j handles coefficient MAX_DEGREE-1-j. Steps whose coefficient index is at
    // or above the degree in use pass the accumulator through unchanged, so every
    // item sees the same number of stages whatever the degree.
    for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
        localparam int K = MAX_DEGREE - 1 - j;

        assign step_active[j] = K < 32'(degree_eff);

        hpe_horner_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .active    (step_active[j]),
            .coef      (coef_reg[K]),
            .in_stage  (chain[j]),
            .out_stage (chain[j+1])
        );
    end

    assign last_stage        = chain[MAX_DEGREE];
    assign last_result.value = last_stage.acc;
    assign last_result.ovf   = last_stage.ovf;

    // Output register with a skid register behind it. The skid register takes
    // the item leaving the pipeline when the output is stalled, and stalls the
    // pipeline on the following cycle, so s_ready never depends on m_ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= last_stage.valid;
            end
        end else if (last_stage.valid && pipe_en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else begin
                out_data_reg <= last_result;
            end
        end else if (last_stage.valid && pipe_en) begin
            skid_data_reg <= last_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_poly_value = out_data_reg.value;
    assign m_overflow   = out_data_reg.ovf;

    // The skid register only fills behind a valid, stalled output.
    `HPE_ASSERT(a_skid_behind_output, skid_valid_reg |-> out_valid_reg)
    `HPE_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
    // While the pipeline is frozen, the item at its end is kept for later.
    `HPE_ASSERT(a_pipe_holds, !pipe_en |=> $stable(last_stage))
    `HPE_ASSERT_RST(a_reset_clears, !aresetn |=> !out_valid_reg && !skid_valid_reg)

endmodule
